// ----- design/ptmst_pkg.sv -----
// Package for the polar-to-two-motor step target pipeline.
// Holds the geometry constants, the reciprocal divider constants, the register indexes and the stage payload types.
// No dependencies.
`timescale 1ns / 1ps
package ptmst_pkg;

	localparam int unsigned DEG_QUADRANT  = 90;
	localparam int unsigned DEG_CIRCLE    = 360;
	localparam int unsigned NUM_QUADRANTS = 4;

	localparam int unsigned QUAD_W = $clog2(NUM_QUADRANTS);

	// round(p / 90) = floor((p + 45) / 90), done as floor(q * RECIP_90 / 2^RECIP_SHIFT).
	// Exact for q below 2^21 / 28, far above the largest q of 22995.
	localparam int unsigned ROUND_BIAS  = DEG_QUADRANT / 2;
	localparam int unsigned RECIP_SHIFT = 21;
	localparam int unsigned RECIP_90    = ((1 << RECIP_SHIFT) + DEG_QUADRANT - 1) / DEG_QUADRANT;

	typedef enum logic [1:0] {
		CFG_AMP_LIMIT     = 2'd0,
		CFG_MOTOR1_SPU    = 2'd1,
		CFG_MOTOR2_SPU    = 2'd2,
		CFG_DEFAULT_SPEED = 2'd3
	} cfg_index_t;

	// Fields carried unchanged down the pipeline
	typedef struct packed {
		logic [7:0]          amp;
		logic [QUAD_W-1:0]   quad;
		logic [7:0]          spd;
		logic signed [23:0]  pos1;
		logic signed [23:0]  pos2;
	} carry_t;

	typedef struct packed {
		carry_t     c;
		logic [6:0] weight;
	} front_t;

	typedef struct packed {
		carry_t     c;
		logic [7:0] a1;
	} split_t;

	typedef struct packed {
		logic signed [24:0] travel1;
		logic signed [24:0] travel2;
		logic [7:0]         spd;
	} result_t;

endpackage

// ----- design/ptmst_front.sv -----
// Front stage: amplitude saturation, angle wrap, quadrant and split weight, speed select.
// Depends on ptmst_pkg.
`timescale 1ns / 1ps
module ptmst_front import ptmst_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         amplitude,
	input  logic [8:0]         angle,
	input  logic               speed_given,
	input  logic [7:0]         speed,
	input  logic signed [23:0] motor1_position,
	input  logic signed [23:0] motor2_position,
	input  logic [7:0]         amp_limit,
	input  logic [7:0]         default_speed,
	output logic               out_valid,
	input  logic               out_ready,
	output front_t             out_data
);

	logic              v_s1;
	front_t            d_s1;
	logic [8:0]        ang_wrap;
	logic [6:0]        rem;
	logic [QUAD_W-1:0] quad;
	front_t            nxt;

	assign in_ready = !v_s1 || out_ready;

	always_comb begin
		ang_wrap = (angle >= 9'(DEG_CIRCLE)) ? angle - 9'(DEG_CIRCLE) : angle;
		if (ang_wrap >= 9'(3 * DEG_QUADRANT)) begin
			quad = 2'd3;
			rem  = 7'(ang_wrap - 9'(3 * DEG_QUADRANT));
		end else if (ang_wrap >= 9'(2 * DEG_QUADRANT)) begin
			quad = 2'd2;
			rem  = 7'(ang_wrap - 9'(2 * DEG_QUADRANT));
		end else if (ang_wrap >= 9'(DEG_QUADRANT)) begin
			quad = 2'd1;
			rem  = 7'(ang_wrap - 9'(DEG_QUADRANT));
		end else begin
			quad = 2'd0;
			rem  = ang_wrap[6:0];
		end
		nxt.c.amp  = (amplitude > amp_limit) ? amp_limit : amplitude;
		nxt.c.quad = quad;
		nxt.c.spd  = speed_given ? speed : default_speed;
		nxt.c.pos1 = motor1_position;
		nxt.c.pos2 = motor2_position;
		// first and third quadrants favour motor 1 near the start of the quadrant
		nxt.weight = quad[0] ? rem : 7'(DEG_QUADRANT) - rem;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			d_s1 <= nxt;
		end
	end

	assign out_valid = v_s1;
	assign out_data  = d_s1;

endmodule

// ----- design/ptmst_split.sv -----
// Split stages: amplitude times weight, then rounded division by 90 through a reciprocal.
// Depends on ptmst_pkg.
`timescale 1ns / 1ps
module ptmst_split import ptmst_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  front_t in_data,
	output logic   out_valid,
	input  logic   out_ready,
	output split_t out_data
);

	logic        v_s2, v_s3;
	logic        adv_s2, adv_s3;
	logic [14:0] q_s2;
	carry_t      c_s2;
	split_t      d_s3;
	logic [29:0] recip_prod;

	assign adv_s3   = !v_s3 || out_ready;
	assign adv_s2   = !v_s2 || adv_s3;
	assign in_ready = adv_s2;

	assign recip_prod = 30'(q_s2) * 30'(RECIP_90);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv_s2) v_s2 <= in_valid;
			if (adv_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && in_valid) begin
			q_s2 <= 15'(in_data.c.amp) * 15'(in_data.weight) + 15'(ROUND_BIAS);
			c_s2 <= in_data.c;
		end
		if (adv_s3 && v_s2) begin
			d_s3.c  <= c_s2;
			d_s3.a1 <= recip_prod[RECIP_SHIFT +: 8];
		end
	end

	assign out_valid = v_s3;
	assign out_data  = d_s3;

endmodule

// ----- design/ptmst_scale.sv -----
// Scale stages: shares times steps per unit, then quadrant sign and subtraction of position.
// Depends on ptmst_pkg.
`timescale 1ns / 1ps
module ptmst_scale import ptmst_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  split_t      in_data,
	input  logic [14:0] motor1_steps_per_unit,
	input  logic [14:0] motor2_steps_per_unit,
	output logic        out_valid,
	input  logic        out_ready,
	output result_t     out_data
);

	logic               v_s4, v_s5;
	logic               adv_s4, adv_s5;
	logic [22:0]        t1_s4, t2_s4;
	logic               neg1_s4, neg2_s4;
	logic [7:0]         spd_s4;
	logic signed [23:0] pos1_s4, pos2_s4;
	result_t            d_s5;
	logic [7:0]         a2;
	logic [24:0]        tgt1, tgt2;

	assign adv_s5   = !v_s5 || out_ready;
	assign adv_s4   = !v_s4 || adv_s5;
	assign in_ready = adv_s4;

	// a1 never exceeds the amplitude, so the difference stays non-negative
	assign a2 = in_data.c.amp - in_data.a1;

	always_comb begin
		tgt1 = neg1_s4 ? 25'(0) - {2'b00, t1_s4} : {2'b00, t1_s4};
		tgt2 = neg2_s4 ? 25'(0) - {2'b00, t2_s4} : {2'b00, t2_s4};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (adv_s4) v_s4 <= in_valid;
			if (adv_s5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s4 && in_valid) begin
			t1_s4   <= 23'(in_data.a1) * 23'(motor1_steps_per_unit);
			t2_s4   <= 23'(a2) * 23'(motor2_steps_per_unit);
			neg1_s4 <= (in_data.c.quad == 2'd1) || (in_data.c.quad == 2'd2);
			neg2_s4 <= in_data.c.quad[1];
			spd_s4  <= in_data.c.spd;
			pos1_s4 <= in_data.c.pos1;
			pos2_s4 <= in_data.c.pos2;
		end
		if (adv_s5 && v_s4) begin
			d_s5.travel1 <= signed'(tgt1 - {pos1_s4[23], pos1_s4});
			d_s5.travel2 <= signed'(tgt2 - {pos2_s4[23], pos2_s4});
			d_s5.spd     <= spd_s4;
		end
	end

	assign out_valid = v_s5;
	assign out_data  = d_s5;

endmodule

// ----- design/polar_to_two_motor_step_targets.sv -----
// Top level of the polar move to two-motor step travel pipeline.
// Depends on ptmst_pkg, ptmst_front, ptmst_split and ptmst_scale.
`timescale 1ns / 1ps
// Usage:
//   Slave stream (s_axis_*) takes one absolute move command per transaction: amplitude,
//   angle in degrees, speed and the two current motor positions in tdata, with the
//   speed-given flag in tuser. Master stream (m_axis_*) returns one transaction per
//   command: the signed step travel of each motor and the speed for both step generators.
//   The plain write port (cfg_we, cfg_index, cfg_data) sets the amplitude ceiling, the
//   steps per unit of each motor and the default speed; write it only while the pipeline
//   is empty.
// Timing:
//   Five register stages; m_axis_tvalid rises once an accepted command has passed all five,
//   and its result is taken on a rising edge with m_axis_tready high.
//   One command is taken every cycle while m_axis_tready stays high, set by the pipelined stages.
// Reset:
//   arst_n empties every stage and loads the register defaults (ceiling 100, 181 steps
//   per unit on both motors, default speed 0).
// Stalls:
//   When m_axis_tready is low the result holds and the stages behind it keep filling any
//   bubbles; s_axis_tready falls only once every stage holds a command.
module polar_to_two_motor_step_targets import ptmst_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [79:0] s_axis_tdata,  // amplitude[7:0], angle[16:8], speed[24:17],
	                                   // motor1_position[48:25], motor2_position[72:49], zeros
	input  logic [0:0]  s_axis_tuser,  // speed_given[0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,  // motor1_travel[24:0], motor2_travel[49:25],
	                                   // move_speed[57:50], zeros
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [14:0] cfg_data
);

	// Configuration registers
	logic [7:0]  amp_limit_q;
	logic [14:0] motor1_spu_q;
	logic [14:0] motor2_spu_q;
	logic [7:0]  default_speed_q;

	// Inter-stage streams
	logic    front_valid, front_ready;
	front_t  front_data;
	logic    split_valid, split_ready;
	split_t  split_data;
	result_t result;

	// Write the addressed register; every index maps to one register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amp_limit_q     <= 8'd100;
			motor1_spu_q    <= 15'd181;
			motor2_spu_q    <= 15'd181;
			default_speed_q <= 8'd0;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				CFG_AMP_LIMIT:     amp_limit_q     <= cfg_data[7:0];
				CFG_MOTOR1_SPU:    motor1_spu_q    <= cfg_data;
				CFG_MOTOR2_SPU:    motor2_spu_q    <= cfg_data;
				CFG_DEFAULT_SPEED: default_speed_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Stage 1: saturate, wrap, find quadrant and split weight
	ptmst_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (s_axis_tvalid),
		.in_ready        (s_axis_tready),
		.amplitude       (s_axis_tdata[7:0]),
		.angle           (s_axis_tdata[16:8]),
		.speed_given     (s_axis_tuser[0]),
		.speed           (s_axis_tdata[24:17]),
		.motor1_position (signed'(s_axis_tdata[48:25])),
		.motor2_position (signed'(s_axis_tdata[72:49])),
		.amp_limit       (amp_limit_q),
		.default_speed   (default_speed_q),
		.out_valid       (front_valid),
		.out_ready       (front_ready),
		.out_data        (front_data)
	);

	// Stages 2 and 3: weighted product, rounded divide by 90
	ptmst_split u_split (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_ready  (front_ready),
		.in_data   (front_data),
		.out_valid (split_valid),
		.out_ready (split_ready),
		.out_data  (split_data)
	);

	// Stages 4 and 5: scale to steps, apply quadrant sign, subtract position
	ptmst_scale u_scale (
		.clk                   (clk),
		.arst_n                (arst_n),
		.in_valid              (split_valid),
		.in_ready              (split_ready),
		.in_data               (split_data),
		.motor1_steps_per_unit (motor1_spu_q),
		.motor2_steps_per_unit (motor2_spu_q),
		.out_valid             (m_axis_tvalid),
		.out_ready             (m_axis_tready),
		.out_data              (result)
	);

	// Pack the result, zero-fill to whole bytes
	assign m_axis_tdata = {6'd0, result.spd, result.travel2, result.travel1};

endmodule

// ----- dv/travel_checker.sv -----
// Checker for the polar-to-two-motor step travel block.
// Watches the command, result and register write ports, predicts each result, compares.
// Depends on ptmst_pkg for the register indexes, the geometry constants and result_t.
`timescale 1ns / 1ps
module travel_checker import ptmst_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [79:0] s_axis_tdata,  // amplitude, angle, speed, motor1_position,
	                                   // motor2_position, zeros
	input  logic [0:0]  s_axis_tuser,  // speed_given
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [63:0] m_axis_tdata,  // motor1_travel, motor2_travel, move_speed, zeros
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [14:0] cfg_data,
	output int          error_count,
	output int          pending
);

	logic [7:0]  amp_ceiling;
	logic [14:0] m1_spu;
	logic [14:0] m2_spu;
	logic [7:0]  dflt_speed;

	result_t expected_moves[$];
	result_t want;
	result_t got;

	// Split the saturated amplitude by quadrant, scale and sign it, subtract the position
	function automatic result_t predict_travel(input logic [79:0] d, input logic sg);
		int unsigned amp;
		int unsigned ang;
		int unsigned quad;
		int unsigned rem;
		int unsigned share1;
		int unsigned share2;
		longint      target1;
		longint      target2;
		result_t     res;
		amp  = d[7:0];
		ang  = d[16:8] % DEG_CIRCLE;
		quad = ang / DEG_QUADRANT;
		rem  = ang % DEG_QUADRANT;
		if (amp > amp_ceiling)
			amp = amp_ceiling;
		// round half away from zero: floor((2p + 90) / 180)
		if (quad == 0 || quad == 2)
			share1 = (2 * amp * (DEG_QUADRANT - rem) + DEG_QUADRANT) / (2 * DEG_QUADRANT);
		else
			share1 = (2 * amp * rem + DEG_QUADRANT) / (2 * DEG_QUADRANT);
		share2  = amp - share1;
		target1 = longint'(share1) * longint'(m1_spu);
		target2 = longint'(share2) * longint'(m2_spu);
		if (quad == 1 || quad == 2)
			target1 = -target1;
		if (quad == 2 || quad == 3)
			target2 = -target2;
		res.travel1 = 25'(target1 - longint'($signed(d[48:25])));
		res.travel2 = 25'(target2 - longint'($signed(d[72:49])));
		res.spd     = sg ? d[24:17] : dflt_speed;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amp_ceiling = 8'd100;
			m1_spu      = 15'd181;
			m2_spu      = 15'd181;
			dflt_speed  = 8'd0;
			expected_moves.delete();
			error_count = 0;
			pending     = 0;
		end else begin
			// retire first, so a result can never match a command of the same edge
			if (m_axis_tvalid && m_axis_tready) begin
				got.travel1 = m_axis_tdata[24:0];
				got.travel2 = m_axis_tdata[49:25];
				got.spd     = m_axis_tdata[57:50];
				if (expected_moves.size() == 0) begin
					$error("result transaction with no command outstanding");
					error_count++;
				end else begin
					want = expected_moves.pop_front();
					if (got.travel1 !== want.travel1) begin
						$error("motor1_travel: expected %0d, actual %0d", want.travel1, got.travel1);
						error_count++;
					end
					if (got.travel2 !== want.travel2) begin
						$error("motor2_travel: expected %0d, actual %0d", want.travel2, got.travel2);
						error_count++;
					end
					if (got.spd !== want.spd) begin
						$error("move_speed: expected %0d, actual %0d", want.spd, got.spd);
						error_count++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_moves.push_back(predict_travel(s_axis_tdata, s_axis_tuser[0]));
			if (cfg_we) begin
				case (cfg_index_t'(cfg_index))
					CFG_AMP_LIMIT:     amp_ceiling = cfg_data[7:0];
					CFG_MOTOR1_SPU:    m1_spu      = cfg_data;
					CFG_MOTOR2_SPU:    m2_spu      = cfg_data;
					CFG_DEFAULT_SPEED: dflt_speed  = cfg_data[7:0];
					default: ;
				endcase
			end
			pending = expected_moves.size();
		end
	end

endmodule

// ----- dv/testbench.sv -----
// Top of the polar-to-two-motor step travel testbench: clock, reset, stimulus and verdict.
// Depends on ptmst_pkg, polar_to_two_motor_step_targets and travel_checker.
`timescale 1ns / 1ps
module testbench;
	import ptmst_pkg::*;

	localparam int STALL_LIMIT = 2000;  // cycles with no transaction on either stream
	localparam int HOLD_CYCLES = 64;    // long receiver hold-off, well past the pipe depth
	localparam int DRAIN_GAP   = 8;     // pipeline latency plus margin

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [79:0] s_axis_tdata = '0;  // amplitude[7:0], angle[16:8], speed[24:17],
	                                 // motor1_position[48:25], motor2_position[72:49], zeros
	logic [0:0]  s_axis_tuser = '0;  // speed_given[0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;       // motor1_travel[24:0], motor2_travel[49:25],
	                                 // move_speed[57:50], zeros
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = CFG_AMP_LIMIT;
	logic [14:0] cfg_data = '0;

	int error_count;
	int pending;
	int quiet_cycles = 0;

	bit tx_gaps  = 1'b1;  // sender idles at random
	bit rx_gaps  = 1'b1;  // receiver stalls at random
	bit hold_req = 1'b0;  // ask the receiver for one long hold-off

	always #1 clk = ~clk;

	polar_to_two_motor_step_targets uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	travel_checker travel_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.error_count   (error_count),
		.pending       (pending)
	);

	// Receiver: at most one assignment to tready per falling edge. A hold request drops tready
	// for a long stretch so the pipe fills and backs up onto the command stream.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				m_axis_tready <= rx_gaps ? ($urandom_range(99) >= 31) : 1'b1;
			end
		end
	end

	// Watchdog: end the run if neither stream moves a transaction for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// Offer one command; idle first at random with noise on the data, then hold
	// the transaction until it is accepted. Returns on the falling edge after acceptance.
	task automatic send_move(input logic [7:0] amp, input logic [8:0] ang, input logic sg,
	                         input logic [7:0] spd, input logic [23:0] pos1,
	                         input logic [23:0] pos2);
		while (tx_gaps && $urandom_range(99) < 31) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= 80'({$urandom, $urandom, $urandom});
			s_axis_tuser  <= 1'($urandom);
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {7'd0, pos2, pos1, spd, ang, amp};
		s_axis_tuser  <= sg;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	// Random command: mostly uniform fields, with some weight on zero, full scale,
	// quadrant boundaries and the position extremes
	task automatic send_random_move();
		logic [7:0]  amp;
		logic [8:0]  ang;
		logic [23:0] pos1;
		logic [23:0] pos2;
		case ($urandom_range(9))
			0:       amp = 8'd0;
			1:       amp = 8'd255;
			default: amp = 8'($urandom_range(255));
		endcase
		if ($urandom_range(4) == 0)
			ang = 9'(45 * $urandom_range(11));
		else
			ang = 9'($urandom_range(511));
		pos1 = ($urandom_range(9) == 0) ? {1'($urandom_range(1)), {23{$urandom_range(1) == 1}}}
		                                 : 24'($urandom);
		pos2 = ($urandom_range(9) == 0) ? {1'($urandom_range(1)), {23{$urandom_range(1) == 1}}}
		                                 : 24'($urandom);
		send_move(amp, ang, 1'($urandom), 8'($urandom), pos1, pos2);
	endtask

	// Write all four registers back to back; junk fills the unused upper bits of the
	// 8-bit registers, which the block must drop
	task automatic set_config(input logic [7:0] ceiling, input logic [14:0] spu1,
	                          input logic [14:0] spu2, input logic [7:0] dspd, input bit junk);
		logic [6:0] fill;
		fill = junk ? 7'($urandom) : 7'd0;
		cfg_we    <= 1'b1;
		cfg_index <= CFG_AMP_LIMIT;
		cfg_data  <= {fill, ceiling};
		@(negedge clk);
		cfg_index <= CFG_MOTOR1_SPU;
		cfg_data  <= spu1;
		@(negedge clk);
		cfg_index <= CFG_MOTOR2_SPU;
		cfg_data  <= spu2;
		@(negedge clk);
		fill = junk ? 7'($urandom) : 7'd0;
		cfg_index <= CFG_DEFAULT_SPEED;
		cfg_data  <= {fill, dspd};
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Drop valid and let every outstanding result come back before touching registers
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		wait (pending == 0);
		repeat (DRAIN_GAP) @(negedge clk);
	endtask

	initial begin
		int n_items;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed, reset defaults: ceiling 100, 181 steps per unit, default speed 0
		send_move(8'd0,   9'd0,   1'b1, 8'd255, 24'd0, 24'd0);
		send_move(8'd255, 9'd0,   1'b0, 8'd0,   24'd0, 24'd0);  // saturate, default speed
		send_move(8'd100, 9'd45,  1'b1, 8'd1,   24'd5, -24'd5);
		send_move(8'd100, 9'd89,  1'b1, 8'd2,   24'd0, 24'd0);
		send_move(8'd100, 9'd90,  1'b1, 8'd3,   24'd0, 24'd0);
		send_move(8'd100, 9'd135, 1'b0, 8'd4,   24'd0, 24'd0);
		send_move(8'd100, 9'd179, 1'b1, 8'd5,   24'd0, 24'd0);
		send_move(8'd100, 9'd180, 1'b1, 8'd6,   24'd0, 24'd0);
		send_move(8'd100, 9'd225, 1'b1, 8'd7,   24'd0, 24'd0);
		send_move(8'd100, 9'd270, 1'b1, 8'd8,   24'd0, 24'd0);
		send_move(8'd100, 9'd315, 1'b1, 8'd9,   24'd0, 24'd0);
		send_move(8'd100, 9'd359, 1'b1, 8'd10,  24'd0, 24'd0);
		send_move(8'd100, 9'd360, 1'b1, 8'd11,  24'd0, 24'd0);  // wraps to 0
		send_move(8'd100, 9'd400, 1'b1, 8'd12,  24'd0, 24'd0);  // wraps to 40
		send_move(8'd100, 9'd511, 1'b1, 8'd13,  24'd0, 24'd0);
		send_move(8'd1,   9'd45,  1'b1, 8'd14,  24'd0, 24'd0);  // half share, rounds up
		send_move(8'd1,   9'd225, 1'b1, 8'd15,  24'd0, 24'd0);
		send_move(8'd99,  9'd30,  1'b1, 8'd16,  24'h800000, 24'h7FFFFF);
		send_move(8'd99,  9'd300, 1'b1, 8'd17,  24'h7FFFFF, 24'h800000);
		send_move(8'd101, 9'd10,  1'b1, 8'd170, 24'd1, 24'd1);  // just over the ceiling
		drain_results();

		// Zero ceiling: every amplitude collapses to nothing, travel is minus position
		set_config(8'd0, 15'd181, 15'd181, 8'd85, 1'b0);
		send_move(8'd255, 9'd0,   1'b0, 8'd0,   24'd0, 24'd0);
		send_move(8'd255, 9'd100, 1'b1, 8'd42,  24'h800000, 24'h7FFFFF);
		send_move(8'd0,   9'd511, 1'b0, 8'd255, 24'h123456, 24'hFEDCBA);
		drain_results();

		// Random phases, each under its own register setting
		for (int phase = 0; phase < 7; phase++) begin
			n_items = 130;
			tx_gaps = 1'b1;
			rx_gaps = 1'b1;
			case (phase)
				0: begin
					// largest travel magnitudes, and the stretch with no idling on either side
					set_config(8'd255, 15'd32767, 15'd32767, 8'd255, 1'b0);
					tx_gaps = 1'b0;
					rx_gaps = 1'b0;
				end
				1: set_config(8'd1, 15'd1, 15'd32767, 8'($urandom), 1'b1);
				2: begin
					set_config(8'($urandom_range(1, 255)), 15'($urandom), 15'($urandom),
					           8'($urandom), 1'b0);
					tx_gaps  = 1'b0;
					hold_req = 1'b1;  // receiver backs up while commands keep coming
				end
				3: set_config(8'd100, 15'd181, 15'd181, 8'd0, 1'b0);
				4: begin
					set_config(8'd0, 15'($urandom), 15'($urandom), 8'($urandom), 1'b1);
					n_items = 30;
				end
				default: set_config(8'($urandom), 15'($urandom), 15'($urandom),
				                    8'($urandom), 1'b1);
			endcase
			repeat (n_items) send_random_move();
			drain_results();
		end

		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ----- polar_to_two_motor_step_targets.f -----
design/ptmst_pkg.sv
design/ptmst_front.sv
design/ptmst_split.sv
design/ptmst_scale.sv
design/polar_to_two_motor_step_targets.sv
dv/travel_checker.sv
dv/testbench.sv
